FILE: hw/rtl/lmt_pkg.sv
`timescale 1ns / 1ps
// Shared types, timing constants and helpers for the LCD mode timing controller.
// No dependencies; used by every module of the block.
package lmt_pkg;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } lmt_mode_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_COMPARE_LINE = 2'd0,
      CSR_IRQ_ENABLES  = 2'd1,
      CSR_DISPLAY_ON   = 2'd2
   } lmt_csr_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int ELAPSED_W   = 6;
   localparam int LINE_W      = 8;
   localparam int ACC_W       = 8;
   localparam int IRQ_EN_W    = 4;

   // Mode durations in machine cycles
   localparam logic [ACC_W-1:0] OAM_CYCLES    = 8'd20;
   localparam logic [ACC_W-1:0] XFER_CYCLES   = 8'd43;
   localparam logic [ACC_W-1:0] HBLANK_CYCLES = 8'd51;
   localparam logic [ACC_W-1:0] VBLANK_CYCLES = 8'd114;
   localparam logic [ACC_W-1:0] ACC_MAX       = 8'd255;

   localparam logic [LINE_W-1:0] LAST_VISIBLE_LINE = 8'd143;
   localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [LINE_W-1:0] FRAME_WRAP_LINE   = 8'd154;
   localparam logic [LINE_W-1:0] FIRST_LINE        = 8'd0;

   // Bits of the status interrupt enable register
   localparam int IRQ_EN_HBLANK = 0;
   localparam int IRQ_EN_VBLANK = 1;
   localparam int IRQ_EN_OAM    = 2;
   localparam int IRQ_EN_COINC  = 3;

   typedef struct packed {
      logic [LINE_W-1:0]   compare_line;
      logic [IRQ_EN_W-1:0] irq_enables;
      logic                display_on;
   } lmt_cfg_type;

   typedef struct packed {
      lmt_mode_type        mode;
      logic [LINE_W-1:0]   line;
      logic [ACC_W-1:0]    acc;
      logic                coincide;
      logic                vram_ok;
      logic                oam_ok;
   } lmt_state_type;

   typedef struct packed {
      lmt_mode_type        mode;
      logic [LINE_W-1:0]   line;
      logic                coincide;
      logic                vram_open;
      logic                oam_open;
      logic                stat_irq;
      logic                vblank_irq;
      logic                render_strobe;
   } lmt_result_type;

   // VRAM access after entering a mode
   function automatic logic vram_access(input lmt_mode_type m, input logic display_on);
      return !display_on || (m != MODE_XFER);
   endfunction

   // OAM access after entering a mode
   function automatic logic oam_access(input lmt_mode_type m, input logic display_on);
      return !display_on || (m == MODE_HBLANK) || (m == MODE_VBLANK);
   endfunction

endpackage

FILE: hw/rtl/lmt_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one timing step of the LCD controller.
// Depends on lmt_pkg.
module lmt_step import lmt_pkg::*; (
   input  lmt_state_type        state,
   input  lmt_cfg_type          cfg,
   input  logic [ELAPSED_W-1:0] elapsed_cycles,
   output lmt_state_type        state_next,
   output lmt_result_type       result
);

   logic [ACC_W:0]    sum;
   logic [ACC_W-1:0]  acc_sat;
   logic [LINE_W-1:0] line_inc;
   logic              coin_inc;
   logic              coin_first;
   logic              stat;
   logic              vbl;
   logic              rend;
   lmt_state_type     nxt;

   assign sum      = {1'b0, state.acc} + {{(ACC_W + 1 - ELAPSED_W){1'b0}}, elapsed_cycles};
   assign acc_sat  = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
   assign line_inc = state.line + 8'd1;
   assign coin_inc   = (line_inc == cfg.compare_line);
   assign coin_first = (FIRST_LINE == cfg.compare_line);

   always_comb begin
      nxt      = state;
      nxt.acc  = acc_sat;
      stat     = 1'b0;
      vbl      = 1'b0;
      rend     = 1'b0;
      unique case (state.mode)
         MODE_OAM: begin
            if (acc_sat >= OAM_CYCLES) begin
               nxt.acc     = acc_sat - OAM_CYCLES;
               nxt.mode    = MODE_XFER;
               nxt.vram_ok = vram_access(MODE_XFER, cfg.display_on);
               nxt.oam_ok  = oam_access(MODE_XFER, cfg.display_on);
            end
         end
         MODE_XFER: begin
            if (acc_sat >= XFER_CYCLES) begin
               nxt.acc     = acc_sat - XFER_CYCLES;
               nxt.mode    = MODE_HBLANK;
               nxt.vram_ok = vram_access(MODE_HBLANK, cfg.display_on);
               nxt.oam_ok  = oam_access(MODE_HBLANK, cfg.display_on);
               stat        = cfg.irq_enables[IRQ_EN_HBLANK];
               rend        = cfg.display_on;
            end
         end
         MODE_HBLANK: begin
            if (acc_sat >= HBLANK_CYCLES) begin
               if (state.line == LAST_VISIBLE_LINE) begin
                  nxt.mode    = MODE_VBLANK;
                  nxt.vram_ok = vram_access(MODE_VBLANK, cfg.display_on);
                  nxt.oam_ok  = oam_access(MODE_VBLANK, cfg.display_on);
                  vbl         = 1'b1;
                  stat        = cfg.irq_enables[IRQ_EN_VBLANK];
               end else begin
                  nxt.mode    = MODE_OAM;
                  nxt.vram_ok = vram_access(MODE_OAM, cfg.display_on);
                  nxt.oam_ok  = oam_access(MODE_OAM, cfg.display_on);
                  stat        = cfg.irq_enables[IRQ_EN_OAM];
               end
               nxt.acc      = acc_sat - HBLANK_CYCLES;
               nxt.line     = line_inc;
               nxt.coincide = coin_inc;
               stat         = stat | (coin_inc & cfg.irq_enables[IRQ_EN_COINC]);
            end
         end
         MODE_VBLANK: begin
            if (acc_sat >= VBLANK_CYCLES) begin
               nxt.acc      = acc_sat - VBLANK_CYCLES;
               nxt.line     = line_inc;
               nxt.coincide = coin_inc;
               stat         = coin_inc & cfg.irq_enables[IRQ_EN_COINC];
               // frame wrap: line 154 is compared, then line 0 in OAM search
               if (line_inc == FRAME_WRAP_LINE) begin
                  nxt.mode     = MODE_OAM;
                  nxt.vram_ok  = vram_access(MODE_OAM, cfg.display_on);
                  nxt.oam_ok   = oam_access(MODE_OAM, cfg.display_on);
                  nxt.line     = FIRST_LINE;
                  nxt.coincide = coin_first;
                  stat = stat | (coin_first & cfg.irq_enables[IRQ_EN_COINC])
                              | cfg.irq_enables[IRQ_EN_OAM];
               end
            end
         end
         default: begin
            nxt = state;
         end
      endcase
   end

   assign state_next           = nxt;
   assign result.mode          = nxt.mode;
   assign result.line          = nxt.line;
   assign result.coincide      = nxt.coincide;
   assign result.vram_open     = nxt.vram_ok;
   assign result.oam_open      = nxt.oam_ok;
   assign result.stat_irq      = stat;
   assign result.vblank_irq    = vbl;
   assign result.render_strobe = rend;

endmodule

FILE: hw/rtl/lcd_mode_timing_controller.sv
`timescale 1ns / 1ps
// Top level of the LCD scanline mode timing controller: handshakes, state, config.
// Depends on lmt_pkg and lmt_step.
//
// Each request carries the machine cycles elapsed since the previous one; the
// controller adds them to a saturating 8-bit cycle counter, makes at most one
// mode transition (OAM search, then transfer, then HBlank per visible line, VBlank from
// line 144, frame wrap after line 153) and returns one result: mode, line, the
// line-compare flag, VRAM/OAM access and pulses for the status interrupt, the
// vertical blank interrupt and the line render strobe. The controller takes one
// request per clock while req_stall is low: a request lands in the input register,
// and one pass of step logic against the timing state produces the result
// register and the new state together. The result register holds while rsp_stall
// is high, and the input register then keeps one more request, so req_stall rises
// only when both are full. Configuration registers (compare line, interrupt
// enables, display on) are written through the csr_ port, by the user only while
// no request is in flight (not enforced by the block); indexes beyond the list are
// dropped. After reset the controller sits in VBlank on line 144, display on.
module lcd_mode_timing_controller import lmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ELAPSED_W-1:0]   req_elapsed_cycles,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_lcd_mode,
   output logic [LINE_W-1:0]      rsp_current_line,
   output logic                   rsp_coincidence,
   output logic                   rsp_vram_open,
   output logic                   rsp_oam_open,
   output logic                   rsp_stat_irq,
   output logic                   rsp_vblank_irq,
   output logic                   rsp_render_strobe,
   // configuration port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [ELAPSED_W-1:0] in_elapsed_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   lmt_result_type       out_result_ff;
   lmt_state_type        state_ff;
   lmt_state_type        state_in;
   lmt_cfg_type          cfg_ff;
   lmt_cfg_type          cfg_in;
   lmt_result_type       step_result;
   logic                 advance;
   logic                 req_take;

   // Move the held request into the result register whenever that slot is free.
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   lmt_step u_step (
      .state          (state_ff),
      .cfg            (cfg_ff),
      .elapsed_cycles (in_elapsed_ff),
      .state_next     (state_in),
      .result         (step_result)
   );

   // Decode configuration writes; unknown indexes leave everything as is.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COMPARE_LINE: cfg_in.compare_line = csr_write_data[LINE_W-1:0];
            CSR_IRQ_ENABLES:  cfg_in.irq_enables  = csr_write_data[IRQ_EN_W-1:0];
            CSR_DISPLAY_ON:   cfg_in.display_on   = csr_write_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Control, timing state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.mode         <= MODE_VBLANK;
         state_ff.line         <= FIRST_VBLANK_LINE;
         state_ff.acc          <= '0;
         state_ff.coincide     <= 1'b0;
         state_ff.vram_ok      <= 1'b1;
         state_ff.oam_ok       <= 1'b1;
         cfg_ff.compare_line   <= '0;
         cfg_ff.irq_enables    <= '0;
         cfg_ff.display_on     <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         // commit the new state only with the request that produced it
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_elapsed_ff <= req_elapsed_cycles;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_lcd_mode      = out_result_ff.mode;
   assign rsp_current_line  = out_result_ff.line;
   assign rsp_coincidence   = out_result_ff.coincide;
   assign rsp_vram_open     = out_result_ff.vram_open;
   assign rsp_oam_open      = out_result_ff.oam_open;
   assign rsp_stat_irq      = out_result_ff.stat_irq;
   assign rsp_vblank_irq    = out_result_ff.vblank_irq;
   assign rsp_render_strobe = out_result_ff.render_strobe;

endmodule

FILE: hw/rtl/lmt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the LCD mode timing controller, bound to the top level.
// Depends on lmt_pkg and lcd_mode_timing_controller.
module lmt_checker import lmt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_lcd_mode,
   input logic [LINE_W-1:0] rsp_current_line,
   input logic              rsp_oam_open,
   input logic              rsp_vblank_irq,
   input logic              rsp_render_strobe
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lcd_mode)
                                 && $stable(rsp_current_line))
      else $error("stalled result changed");

   // Rendering is requested only on the step that enters HBlank.
   a_render_hblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_render_strobe |-> rsp_lcd_mode == MODE_HBLANK)
      else $error("render strobe outside HBlank");

   // The vertical blank interrupt fires on the move to line 144 in VBlank.
   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_irq |->
         rsp_lcd_mode == MODE_VBLANK && rsp_current_line == FIRST_VBLANK_LINE)
      else $error("vblank interrupt off the first blank line");

   // OAM is locked only during OAM search or transfer.
   a_oam_lock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_oam_open |->
         rsp_lcd_mode == MODE_OAM || rsp_lcd_mode == MODE_XFER)
      else $error("OAM locked in a blanking mode");

   // The line count never goes beyond the frame wrap.
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_line <= FRAME_WRAP_LINE)
      else $error("line out of range");

endmodule

bind lcd_mode_timing_controller lmt_checker u_lmt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_lcd_mode      (rsp_lcd_mode),
   .rsp_current_line  (rsp_current_line),
   .rsp_oam_open      (rsp_oam_open),
   .rsp_vblank_irq    (rsp_vblank_irq),
   .rsp_render_strobe (rsp_render_strobe)
);
